>>> design/newton_interpolation_engine_macros.svh
// ---------------------------------------------------------------------------
// newton interpolation engine assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef NEWTON_INTERPOLATION_ENGINE_MACROS_SVH
`define NEWTON_INTERPOLATION_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define NIE_AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nie assertion failed");

// next-cycle implication, disabled while reset is held
`define NIE_AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nie assertion failed");

`endif

>>> design/nie_pkg.sv
// ---------------------------------------------------------------------------
// nie_pkg
// types, constants and helpers shared by the interpolation engine
// ---------------------------------------------------------------------------
`default_nettype none

package nie_pkg;

    localparam int MAX_POINTS = 32;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = $clog2(MAX_POINTS);

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_SAT   = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BK,
        S_BKW,
        S_BJ,
        S_BJW,
        S_DIV,
        S_E0,
        S_E0W,
        S_EI,
        S_EIW,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] v;
        logic        sat;
    } t_satval;

    // signed result from magnitude and sign, clamped to 64 bits
    function automatic t_satval from_mag(input logic [63:0] m, input logic neg);
        t_satval r;
        if (!neg) begin
            if (m > POS_MAX) begin
                r = '{v: POS_MAX, sat: 1'b1};
            end else begin
                r = '{v: m, sat: 1'b0};
            end
        end else begin
            if (m > NEG_MAX) begin
                r = '{v: NEG_MAX, sat: 1'b1};
            end else begin
                r = '{v: 64'd0 - m, sat: 1'b0};
            end
        end
        return r;
    endfunction

    // q32.32 to q40.24, round half away from zero
    function automatic logic [63:0] to_q24(input logic [63:0] c);
        logic [63:0] m;
        logic [63:0] s;
        m = c[63] ? (64'd0 - c) : c;
        s = (m + 64'd128) >> 8;
        return c[63] ? (64'd0 - s) : s;
    endfunction

endpackage

`default_nettype wire

>>> design/nie_ram.sv
// ---------------------------------------------------------------------------
// nie_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module nie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/nie_div.sv
// ---------------------------------------------------------------------------
// nie_div
// restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module nie_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic      [63:0] o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_div, n_div;
    logic [63:0] r_quo, n_quo;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd63;
            n_rem  = '0;
            n_div  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = ge ? diff[15:0] : trial[15:0];
            n_quo = {r_quo[62:0], ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> design/nie_mulq.sv
// ---------------------------------------------------------------------------
// nie_mulq
// q40.24 by q16.16 product back to q40.24, two 32x32 partial products
// ---------------------------------------------------------------------------
`default_nettype none

module nie_mulq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [63:0]          i_acc,
    input  wire logic [33:0]          i_d,
    output logic                      o_done,
    output nie_pkg::t_satval          o_res
);
    import nie_pkg::*;

    logic [1:0]  r_ph, n_ph;
    logic        r_done, n_done;
    logic [63:0] r_ma, n_ma;
    logic [31:0] r_md, n_md;
    logic        r_neg, n_neg;
    logic [63:0] r_plo, n_plo;
    logic [63:0] r_phi, n_phi;
    t_satval     r_res, n_res;
    logic [33:0] dmag;
    logic [31:0] mul_a;
    logic [63:0] prod;
    logic [96:0] sum;

    assign dmag  = i_d[33] ? (34'd0 - i_d) : i_d;
    assign mul_a = (r_ph == 2'd1) ? r_ma[31:0] : r_ma[63:32];
    assign prod  = {32'd0, mul_a} * {32'd0, r_md};
    assign sum   = {33'd0, r_plo} + {1'b0, r_phi, 32'd0} + 97'd32768;

    always_comb begin
        n_ph   = r_ph;
        n_done = 1'b0;
        n_ma   = r_ma;
        n_md   = r_md;
        n_neg  = r_neg;
        n_plo  = r_plo;
        n_phi  = r_phi;
        n_res  = r_res;
        case (r_ph)
            2'd0: begin
                if (i_start) begin
                    n_ma  = i_acc[63] ? (64'd0 - i_acc) : i_acc;
                    n_md  = dmag[31:0];
                    n_neg = i_acc[63] ^ i_d[33];
                    n_ph  = 2'd1;
                end
            end
            2'd1: begin
                n_plo = prod;
                n_ph  = 2'd2;
            end
            2'd2: begin
                n_phi = prod;
                n_ph  = 2'd3;
            end
            default: begin
                if (|sum[96:80]) begin
                    n_res = '{v: (r_neg ? NEG_MAX : POS_MAX), sat: 1'b1};
                end else begin
                    n_res = from_mag(sum[79:16], r_neg);
                end
                n_done = 1'b1;
                n_ph   = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma  <= n_ma;
        r_md  <= n_md;
        r_neg <= n_neg;
        r_plo <= n_plo;
        r_phi <= n_phi;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> design/newton_interpolation_engine.sv
// ---------------------------------------------------------------------------
// newton_interpolation_engine - newton divided-difference interpolator
// load, clear, stray opcode and empty evaluate answer from the output state; an evaluate walks
//   n nodes in horner form, after building each new node k against its k earlier ones
// one transaction in flight; serial divide and multiply set the pace
// synchronous active-low reset empties the table and clears the valid flag of the result register
// ---------------------------------------------------------------------------
`default_nettype none

module newton_interpolation_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // node_x[15:0], node_y[47:16], query_point[79:48]
    input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,   // interp_value[63:0], node_count[69:64], zero pad
    output logic      [2:0]  m_axis_tuser    // status[2:0]
);
    import nie_pkg::*;

    // sequencer state
    t_state r_state, n_state;

    // table bookkeeping
    logic [CNT_W-1:0] r_count, n_count;    // nodes held
    logic [CNT_W-1:0] r_built, n_built;    // coefficients already built
    logic             r_csat, n_csat;      // sticky coefficient saturation

    // build and walk indices
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_i, n_i;

    // datapath
    logic [31:0] r_q, n_q;
    logic [15:0] r_xk, n_xk;
    logic [63:0] r_tv, n_tv;
    logic        r_dneg, n_dneg;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_cadd, n_cadd;
    logic [63:0] r_value, n_value;
    t_status     r_status, n_status;

    // output register
    logic        r_m_tvalid, n_m_tvalid;
    logic [71:0] r_m_tdata, n_m_tdata;
    logic [2:0]  r_m_tuser, n_m_tuser;

    // ram ports
    logic             x_we;
    logic [IDX_W-1:0] x_waddr;
    logic [15:0]      x_wdata;
    logic             d_we;
    logic [IDX_W-1:0] d_waddr;
    logic [63:0]      d_wdata;
    logic [IDX_W-1:0] raddr;
    logic [15:0]      x_rdata;
    logic [63:0]      d_rdata;

    // shared units
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_q;
    logic [15:0] div_divisor;
    logic        mul_start, mul_done;
    logic [33:0] mul_d;
    t_satval     mul_res;

    // input fields
    logic [1:0]  in_opcode;
    logic [15:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_q;
    logic        in_acc;

    // combinational helpers
    logic             dneg;
    logic [16:0]      dx;
    logic [16:0]      dxmag;
    logic [63:0]      add_s;
    logic             add_ovf;
    t_satval          div_fm;
    logic [CNT_W+5:0] cnt_ext;
    logic             out_free;

    assign in_opcode = s_axis_tuser;
    assign in_x      = s_axis_tdata[15:0];
    assign in_y      = s_axis_tdata[47:16];
    assign in_q      = s_axis_tdata[79:48];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_tvalid || m_axis_tready;

    // divided difference operands: node k against node j just read
    assign dneg    = $signed(r_tv) < $signed(d_rdata);
    assign dx      = {r_xk[15], r_xk} - {x_rdata[15], x_rdata};
    assign dxmag   = dx[16] ? (17'd0 - dx) : dx;
    assign div_fm  = from_mag(div_q, r_dneg);

    // horner step accumulate
    assign add_s   = r_acc + r_cadd;
    assign add_ovf = (r_acc[63] == r_cadd[63]) && (add_s[63] != r_acc[63]);

    assign cnt_ext = {6'd0, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_opcode == OP_EVAL && r_count != '0) begin
                        n_state = S_BK;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_BK:  n_state = (r_k == r_count) ? S_E0 : S_BKW;
            S_BKW: n_state = S_BJ;
            S_BJ:  n_state = (r_j == r_k) ? S_BK : S_BJW;
            S_BJW: n_state = (dx == '0) ? S_OUT : S_DIV;
            S_DIV: n_state = div_done ? S_BJ : S_DIV;
            S_E0:  n_state = S_E0W;
            S_E0W: n_state = S_EI;
            S_EI:  n_state = (r_i == '0) ? S_OUT : S_EIW;
            S_EIW: n_state = S_MUL;
            S_MUL: begin
                if (mul_done) begin
                    n_state = mul_res.sat ? S_OUT : S_ADD;
                end
            end
            S_ADD: n_state = add_ovf ? S_OUT : S_EI;
            S_OUT: n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_count      = r_count;
        n_built      = r_built;
        n_csat       = r_csat;
        n_k          = r_k;
        n_j          = r_j;
        n_i          = r_i;
        n_q          = r_q;
        n_xk         = r_xk;
        n_tv         = r_tv;
        n_dneg       = r_dneg;
        n_acc        = r_acc;
        n_cadd       = r_cadd;
        n_value      = r_value;
        n_status     = r_status;
        n_m_tvalid   = r_m_tvalid && !m_axis_tready;
        n_m_tdata    = r_m_tdata;
        n_m_tuser    = r_m_tuser;
        x_we         = 1'b0;
        x_waddr      = r_count[IDX_W-1:0];
        x_wdata      = in_x;
        d_we         = 1'b0;
        d_waddr      = r_count[IDX_W-1:0];
        d_wdata      = {in_y, 32'd0};
        raddr        = r_k[IDX_W-1:0];
        div_start    = 1'b0;
        div_dividend = dneg ? (d_rdata - r_tv) : (r_tv - d_rdata);
        div_divisor  = dxmag[15:0];
        mul_start    = 1'b0;
        mul_d        = {{2{r_q[31]}}, r_q} - {{2{x_rdata[15]}}, x_rdata, 16'd0};
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_value  = '0;
                    n_status = ST_OK;
                    n_q      = in_q;
                    n_k      = r_built;
                    case (in_opcode)
                        OP_LOAD: begin
                            if (r_count < CNT_W'(MAX_POINTS)) begin
                                x_we    = 1'b1;
                                d_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_EVAL: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_built = '0;
                            n_csat  = 1'b0;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_BK: begin
                raddr = r_k[IDX_W-1:0];
            end
            S_BKW: begin
                n_xk = x_rdata;
                n_tv = d_rdata;
                n_j  = '0;
            end
            S_BJ: begin
                raddr = r_j[IDX_W-1:0];
                if (r_j == r_k) begin
                    // coefficient k complete, write it back
                    d_we    = 1'b1;
                    d_waddr = r_k[IDX_W-1:0];
                    d_wdata = r_tv;
                    n_built = r_k + 1'b1;
                    n_k     = r_k + 1'b1;
                end
            end
            S_BJW: begin
                if (dx == '0) begin
                    n_status = ST_DUP;
                    n_value  = '0;
                end else begin
                    div_start = 1'b1;
                    n_dneg    = dneg ^ dx[16];
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_tv   = div_fm.v;
                    n_csat = r_csat | div_fm.sat;
                    n_j    = r_j + 1'b1;
                end
            end
            S_E0: begin
                raddr = IDX_W'(r_count - 1'b1);
                n_i   = r_count - 1'b1;
            end
            S_E0W: begin
                n_acc = to_q24(d_rdata);
            end
            S_EI: begin
                raddr = IDX_W'(r_i - 1'b1);
                if (r_i == '0) begin
                    n_value  = r_acc;
                    n_status = r_csat ? ST_SAT : ST_OK;
                end
            end
            S_EIW: begin
                mul_start = 1'b1;
                n_cadd    = to_q24(d_rdata);
            end
            S_MUL: begin
                if (mul_done) begin
                    if (mul_res.sat) begin
                        n_value  = mul_res.v;
                        n_status = ST_SAT;
                    end else begin
                        n_acc = mul_res.v;
                    end
                end
            end
            S_ADD: begin
                if (add_ovf) begin
                    n_value  = r_acc[63] ? NEG_MAX : POS_MAX;
                    n_status = ST_SAT;
                end else begin
                    n_acc = add_s;
                    n_i   = r_i - 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {2'd0, cnt_ext[5:0], r_value};
                    n_m_tuser  = r_status;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_built    <= '0;
            r_csat     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_built    <= n_built;
            r_csat     <= n_csat;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_j       <= n_j;
        r_i       <= n_i;
        r_q       <= n_q;
        r_xk      <= n_xk;
        r_tv      <= n_tv;
        r_dneg    <= n_dneg;
        r_acc     <= n_acc;
        r_cadd    <= n_cadd;
        r_value   <= n_value;
        r_status  <= n_status;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    // node abscissas
    nie_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (x_waddr),
        .i_wdata (x_wdata),
        .i_raddr (raddr),
        .o_rdata (x_rdata)
    );

    // samples, turned into coefficients in place as they are built
    nie_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (raddr),
        .o_rdata (d_rdata)
    );

    nie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    nie_mulq u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_acc   (r_acc),
        .i_d     (mul_d),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

`default_nettype wire

>>> design/nie_checker.sv
// ---------------------------------------------------------------------------
// nie_checker
// port-level checks on result transactions of the interpolation engine
// ---------------------------------------------------------------------------
`default_nettype none

`include "newton_interpolation_engine_macros.svh"

module nie_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    import nie_pkg::*;

    localparam logic [CNT_W+5:0] FULL_CNT = (CNT_W + 6)'(MAX_POINTS);

    `NIE_AST_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `NIE_AST_IMPLY(a_status_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= ST_EMPTY)
    `NIE_AST_IMPLY(a_value_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK && m_axis_tuser != ST_SAT, m_axis_tdata[63:0] == 64'd0)
    `NIE_AST_IMPLY(a_full_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata[69:64] == FULL_CNT[5:0])

endmodule

bind newton_interpolation_engine nie_checker u_nie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stream-level regression for the newton interpolation engine: node loads,
// evaluations, clears and stray opcodes are checked against a local
// divided-difference predictor under random idling on both sides
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import nie_pkg::*;

    localparam int IDLE_LIMIT = 200000;   // cycles without any transaction
    localparam int N_ITEMS    = 1450;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic [31:0]        y;
        logic [31:0]        q;
        bit                 drain;  // wait for every result before sending
    } t_item;

    typedef struct {
        logic [63:0] value;
        logic [2:0]  status;
        logic [5:0]  count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    t_item   pending_items[$];
    t_result expected_results[$];
    t_item   item_on_bus;
    int      items_sent;
    int      mismatches;
    bit      in_taken;
    bit      stim_done;
    int      tx_idle_pct;
    int      rx_idle_pct;

    // predictor state
    logic signed [15:0] node_xs[MAX_POINTS];
    logic [63:0]        diffs[MAX_POINTS];
    int                 held;
    int                 built;
    bit                 coef_clamped;

    newton_interpolation_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // fixed-point helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic logic [63:0] clamp_signed(input logic [63:0] m, input bit neg,
                                                 inout bit sat);
        if (!neg) begin
            if (m > POS_MAX) begin
                sat = 1'b1;
                return POS_MAX;
            end
            return m;
        end
        if (m > NEG_MAX) begin
            sat = 1'b1;
            return NEG_MAX;
        end
        return 64'd0 - m;
    endfunction

    // exact difference over dx, truncated toward zero
    function automatic logic [63:0] divided_diff(input logic [63:0] a, input logic [63:0] b,
                                                 input int dx, inout bit sat);
        bit          dneg;
        logic [63:0] m;
        logic [63:0] ud;
        dneg = $signed(a) < $signed(b);
        m    = dneg ? b - a : a - b;
        ud   = dx < 0 ? 64'(-dx) : 64'(dx);
        return clamp_signed(m / ud, dneg ^ (dx < 0), sat);
    endfunction

    // q32.32 coefficient to q40.24, half away from zero
    function automatic logic [63:0] coef_to_q24(input logic [63:0] c);
        logic [63:0] s;
        s = (abs64(c) + 64'd128) >> 8;
        return c[63] ? 64'd0 - s : s;
    endfunction

    // q40.24 times q16.16 distance, rounded back to q40.24
    function automatic logic [63:0] scale_by_dist(input logic [63:0] acc,
                                                  input longint d, inout bit sat);
        logic [127:0] p;
        logic [63:0]  md;
        bit           neg;
        md  = d < 0 ? 64'(-d) : 64'(d);
        neg = acc[63] ^ (d < 0);
        p   = 128'(abs64(acc)) * 128'(md) + 128'h8000;
        if (p[127:80] != 0) begin
            sat = 1'b1;
            return neg ? NEG_MAX : POS_MAX;
        end
        return clamp_signed(p[79:16], neg, sat);
    endfunction

    function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b,
                                                inout bit sat);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat = 1'b1;
            return a[63] ? NEG_MAX : POS_MAX;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // predictor: updates the node table and queues the expected result
    // ------------------------------------------------------------------
    task automatic predict_interp(input t_item it);
        t_result r;
        bit          dup;
        bit          sat;
        logic [63:0] tv;
        logic [63:0] acc;
        int          dx;
        longint      d;
        r = '{value: 64'd0, status: ST_OK, count: 6'd0};
        if (it.op == OP_LOAD) begin
            if (held >= MAX_POINTS) begin
                r.status = ST_FULL;
            end else begin
                node_xs[held] = it.x;
                diffs[held]   = {it.y, 32'd0};
                held++;
            end
        end else if (it.op == OP_EVAL) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                dup = 1'b0;
                for (int k = built; k < held && !dup; k++) begin
                    tv = diffs[k];
                    for (int j = 0; j < k; j++) begin
                        dx = int'(node_xs[k]) - int'(node_xs[j]);
                        if (dx == 0) begin
                            dup = 1'b1;
                            break;
                        end
                        tv = divided_diff(tv, diffs[j], dx, coef_clamped);
                    end
                    if (!dup) begin
                        diffs[k] = tv;
                        built    = k + 1;
                    end
                end
                if (dup) begin
                    r.status = ST_DUP;
                end else begin
                    sat = 1'b0;
                    acc = coef_to_q24(diffs[held-1]);
                    for (int i = held - 1; i > 0 && !sat; i--) begin
                        d   = longint'($signed(it.q)) - longint'(node_xs[i-1]) * 65536;
                        acc = scale_by_dist(acc, d, sat);
                        if (!sat) acc = add_clamped(acc, coef_to_q24(diffs[i-1]), sat);
                    end
                    r.value  = acc;
                    r.status = (sat || coef_clamped) ? ST_SAT : ST_OK;
                end
            end
        end else if (it.op == OP_CLEAR) begin
            held         = 0;
            built        = 0;
            coef_clamped = 1'b0;
        end
        r.count = 6'(held);
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    function automatic t_item mk(input logic [1:0] op, input int x, input logic [31:0] y,
                                 input logic [31:0] q);
        t_item it;
        it.op = op; it.x = 16'(x); it.y = y; it.q = q; it.drain = 1'b0;
        return it;
    endfunction

    function automatic logic [31:0] small_y();
        return ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(2000)) - 32'd1000;
    endfunction

    task automatic build_stimulus();
        t_item it;
        int    n;
        int    base;
        int    step;
        int    x;
        int    evals;
        int    lo;
        // directed corners
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 0));                 // empty table
        pending_items.push_back(mk(OP_LOAD, -32768, 32'h7FFF_FFFF, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h7FFF_FFFF));     // single node
        pending_items.push_back(mk(OP_LOAD, 32767, 32'h8000_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h7FFF_FFFF));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h8000_0000));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h0000_0000));
        pending_items.push_back(mk(OP_LOAD, 32767, 32'd5, 0));        // duplicate x
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h0001_0000));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'hFFFF_0000));     // duplicate persists
        pending_items.push_back(mk(3, 0, 0, 0));                        // stray opcode
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, 0, 32'h7FFF_FFFF, 0));     // coefficient clamp
        pending_items.push_back(mk(OP_LOAD, 1, 32'h8000_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h0000_8000));
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
        pending_items.push_back(mk(OP_LOAD, -3, 32'h4000_0000, 0));    // walk clamp
        pending_items.push_back(mk(OP_LOAD, 0, 32'hC000_0000, 0));
        pending_items.push_back(mk(OP_LOAD, 2, 32'h7000_0000, 0));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h7FFF_0000));
        pending_items.push_back(mk(OP_EVAL, 0, 0, 32'h0000_C000));     // interior point
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
        // random sequences: clear, nodes, evaluations, some noise
        while (pending_items.size() < N_ITEMS + 23) begin
            if ($urandom_range(3) != 0) pending_items.push_back(mk(OP_CLEAR, 0, 0, 0));
            n    = ($urandom_range(19) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
            base = $urandom_range(40) - 20;
            step = ($urandom_range(1) ? 1 : -1) * $urandom_range(1, 4);
            lo   = base;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(29) == 0) x = $urandom;                    // any x
                else if ($urandom_range(24) == 0 && i > 0) x = base + step * (i - 1);
                else x = base + step * i;
                if (x < lo) lo = x;
                pending_items.push_back(mk(OP_LOAD, x, small_y(), $urandom));
                if ($urandom_range(15) == 0) pending_items.push_back(mk(3, $urandom,
                                                 $urandom, $urandom));
                if ($urandom_range(7) == 0)
                    pending_items.push_back(mk(OP_EVAL, $urandom, $urandom,
                        32'((lo + $urandom_range(8)) * 65536 + $urandom_range(65535))));
            end
            evals = $urandom_range(1, 3);
            for (int i = 0; i < evals; i++) begin
                it = mk(OP_EVAL, $urandom, $urandom, $urandom);
                if ($urandom_range(4) != 0)
                    it.q = 32'((lo + $urandom_range(3 * n)) * 65536 + $urandom_range(65535)
                               - 32768);
                pending_items.push_back(it);
            end
        end
        pending_items[23].drain = 1'b1;
        pending_items[N_ITEMS / 2].drain = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // driver: one transaction source, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_item nx;
        bit    go;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_idle_pct = (items_sent < N_ITEMS / 3) ? 28 :
                          (items_sent < 2 * N_ITEMS / 3) ? 87 : 0;
            rx_idle_pct = (items_sent < N_ITEMS / 3) ? 87 :
                          (items_sent < 2 * N_ITEMS / 3) ? 28 : 0;
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (!s_axis_tvalid || in_taken) begin
                go = pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct;
                if (go && pending_items[0].drain && expected_results.size() != 0) go = 1'b0;
                if (go) begin
                    nx          = pending_items.pop_front();
                    item_on_bus = nx;
                    items_sent++;
                    s_axis_tdata  <= {nx.q, nx.y, nx.x};
                    s_axis_tuser  <= nx.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input acceptance and result monitor, sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result ex;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) predict_interp(item_on_bus);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction: data %h status %0d",
                                               m_axis_tdata, m_axis_tuser);
            end else begin
                ex = expected_results.pop_front();
                if (m_axis_tdata[63:0] !== ex.value || m_axis_tuser !== ex.status
                    || m_axis_tdata[69:64] !== ex.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: value %h/%h status %0d/%0d count %0d/%0d",
                                 m_axis_tdata[63:0], ex.value, m_axis_tuser, ex.status,
                                 m_axis_tdata[69:64], ex.count);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        mismatches    = 0;
        held          = 0;
        built         = 0;
        coef_clamped  = 1'b0;
        in_taken      = 1'b0;
        build_stimulus();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
